[rtl/dsv_pkg.sv]
// Shared types and constants for the date string validator.
// No dependencies; every other file of the block imports this package.
package dsv_pkg;

   // Field widths
   localparam int CHAR_W  = 8;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 7;
   localparam int DAY_W   = 7;
   localparam int CMON_W  = 4;
   localparam int DIGIT_W = 4;
   localparam int COUNT_W = 3;
   localparam int PAIR_W  = 7;

   // Control/status register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURRENT_YEAR  = 2'd0,
      CSR_CURRENT_MONTH = 2'd1,
      CSR_MIN_YEAR      = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_index_type;

   localparam logic [YEAR_W-1:0] CURRENT_YEAR_RESET  = 14'd2000;
   localparam logic [CMON_W-1:0] CURRENT_MONTH_RESET = 4'd1;
   localparam logic [YEAR_W-1:0] MIN_YEAR_RESET      = 14'd2000;

   // Characters
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;

   // Segment codes of the parser
   localparam logic [1:0] SEG_YEAR  = 2'd0;
   localparam logic [1:0] SEG_MONTH = 2'd1;
   localparam logic [1:0] SEG_DAY   = 2'd2;

   localparam logic [COUNT_W-1:0] YEAR_DIGITS  = 3'd4;
   localparam logic [COUNT_W-1:0] FIELD_DIGITS = 3'd2;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 3'd7;

   // Calendar constants
   localparam logic [MONTH_W-1:0] MONTH_FEB = 7'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 7'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 7'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 7'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 7'd11;
   localparam logic [MONTH_W-1:0] MONTH_MAX = 7'd12;
   localparam logic [DAY_W-1:0]   DAYS_31   = 7'd31;
   localparam logic [DAY_W-1:0]   DAYS_30   = 7'd30;
   localparam logic [DAY_W-1:0]   DAYS_29   = 7'd29;
   localparam logic [DAY_W-1:0]   DAYS_28   = 7'd28;

   // Queue between parser and checker
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One parsed string, handed from parser to checker
   typedef struct packed {
      logic               format_ok;
      logic               leap;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } parsed_type;

   // Limits programmed through the register port
   typedef struct packed {
      logic [YEAR_W-1:0] current_year;
      logic [CMON_W-1:0] current_month;
      logic [YEAR_W-1:0] min_year;
   } limits_type;

endpackage

[rtl/dsv_if.sv]
// Channel interfaces of the date string validator: request, response, register write.
// Depends on dsv_pkg for field widths.
interface dsv_req_if;
   import dsv_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface dsv_rsp_if;
   import dsv_pkg::*;
   logic               valid;
   logic               ready;
   logic               format_ok;
   logic               date_valid;
   logic [YEAR_W-1:0]  year_out;
   logic [MONTH_W-1:0] month_out;
   logic [DAY_W-1:0]   day_out;

   modport source (output valid, output format_ok, output date_valid, output year_out,
                   output month_out, output day_out, input ready);
   modport sink   (input valid, input format_ok, input date_valid, input year_out,
                   input month_out, input day_out, output ready);
endinterface

interface dsv_csr_if;
   import dsv_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[rtl/dsv_front.sv]
// Character parser: checks the YYYY-M(M)-D(D) form and accumulates the fields.
// Depends on dsv_pkg and dsv_req_if; pushes one parsed word per string into the queue.
module dsv_front (
   input  logic                clock,
   input  logic                reset,
   dsv_req_if.sink             req,
   input  logic                q_full,
   output logic                push,
   output dsv_pkg::parsed_type push_data
);
   import dsv_pkg::*;

   logic [1:0]         seg_ff, seg_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff, day_in;
   logic               bad_ff, bad_in;
   logic [DIGIT_W-1:0] prev_ff, prev_in;
   logic [PAIR_W-1:0]  hi2_ff, hi2_in;
   logic [PAIR_W-1:0]  lo2_ff, lo2_in;

   logic               accept;
   logic               is_digit;
   logic [DIGIT_W-1:0] digit;
   logic [COUNT_W-1:0] limit;
   logic [PAIR_W-1:0]  pair;
   logic               form;
   logic               leap;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign is_digit  = (req.char_code >= CHAR_ZERO) && (req.char_code <= CHAR_NINE);
   assign digit     = req.char_code[DIGIT_W-1:0];
   assign limit     = (seg_ff == SEG_YEAR) ? YEAR_DIGITS : FIELD_DIGITS;
   // previous digit and this one, as a two-digit number
   assign pair      = PAIR_W'({prev_ff, 3'b000}) + PAIR_W'({prev_ff, 1'b0}) + PAIR_W'(digit);

   // Advance the parser by one character
   always_comb begin
      seg_in   = seg_ff;
      count_in = count_ff;
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      bad_in   = bad_ff;
      prev_in  = prev_ff;
      hi2_in   = hi2_ff;
      lo2_in   = lo2_ff;
      if (is_digit) begin
         if (count_ff >= limit) begin
            bad_in = 1'b1;
         end else begin
            unique case (seg_ff)
               SEG_YEAR: begin
                  year_in = YEAR_W'({year_ff, 3'b000}) + YEAR_W'({year_ff, 1'b0})
                            + YEAR_W'(digit);
                  prev_in = digit;
                  if (count_ff == 3'd1) hi2_in = pair;
                  if (count_ff == 3'd3) lo2_in = pair;
               end
               SEG_MONTH: begin
                  month_in = MONTH_W'({month_ff, 3'b000}) + MONTH_W'({month_ff, 1'b0})
                             + MONTH_W'(digit);
               end
               default: begin
                  day_in = DAY_W'({day_ff, 3'b000}) + DAY_W'({day_ff, 1'b0})
                           + DAY_W'(digit);
               end
            endcase
         end
         if (count_ff != COUNT_MAX) count_in = count_ff + 3'd1;
      end else if (req.char_code == CHAR_DASH) begin
         if ((seg_ff == SEG_YEAR && count_ff == YEAR_DIGITS) ||
             (seg_ff == SEG_MONTH && count_ff >= 3'd1 && count_ff <= FIELD_DIGITS)) begin
            seg_in   = seg_ff + 2'd1;
            count_in = '0;
         end else begin
            bad_in = 1'b1;
         end
      end else begin
         bad_in = 1'b1;
      end
   end

   // Form verdict on the final character; a year that ends in 00 is leap by its century
   assign form = !bad_in && (seg_in == SEG_DAY) && (count_in >= 3'd1)
                 && (count_in <= FIELD_DIGITS);
   assign leap = (lo2_ff != '0) ? (lo2_ff[1:0] == 2'b00) : (hi2_ff[1:0] == 2'b00);

   assign push = accept && req.last;
   always_comb begin
      push_data.format_ok = form;
      push_data.leap      = leap;
      push_data.year      = form ? year_in  : '0;
      push_data.month     = form ? month_in : '0;
      push_data.day       = form ? day_in   : '0;
   end

   // Hold parser state; clear it after the final character
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff   <= SEG_YEAR;
         count_ff <= '0;
         year_ff  <= '0;
         month_ff <= '0;
         day_ff   <= '0;
         bad_ff   <= 1'b0;
      end else if (accept) begin
         if (req.last) begin
            seg_ff   <= SEG_YEAR;
            count_ff <= '0;
            year_ff  <= '0;
            month_ff <= '0;
            day_ff   <= '0;
            bad_ff   <= 1'b0;
         end else begin
            seg_ff   <= seg_in;
            count_ff <= count_in;
            year_ff  <= year_in;
            month_ff <= month_in;
            day_ff   <= day_in;
            bad_ff   <= bad_in;
         end
      end
   end

   // Year digit history for the leap test
   always_ff @(posedge clock) begin
      if (accept) begin
         prev_ff <= prev_in;
         hi2_ff  <= hi2_in;
         lo2_ff  <= lo2_in;
      end
   end

endmodule

[rtl/dsv_queue.sv]
// Two-entry queue of parsed words between the parser and the checker.
// Depends on dsv_pkg for parsed_type and the queue sizing.
module dsv_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dsv_pkg::parsed_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output dsv_pkg::parsed_type pop_data
);
   import dsv_pkg::*;

   parsed_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   // Store pushed words
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("queue pop while empty");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count did not follow push");

endmodule

[rtl/dsv_back.sv]
// Calendar and limit checker with the registered response stage.
// Depends on dsv_pkg and dsv_rsp_if; takes parsed words from the queue.
module dsv_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  dsv_pkg::parsed_type q_data,
   output logic                pop,
   input  dsv_pkg::limits_type limits,
   dsv_rsp_if.source           rsp
);
   import dsv_pkg::*;

   logic               valid_ff;
   logic               fmt_ff;
   logic               date_ok_ff, date_ok_in;
   logic [YEAR_W-1:0]  year_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [DAY_W-1:0]   day_ff;
   logic [DAY_W-1:0]   day_limit;
   logic               year_ok;
   logic               month_ok;

   // Days allowed in the parsed month
   always_comb begin
      case (q_data.month) inside
         MONTH_FEB:                                  day_limit = q_data.leap ? DAYS_29 : DAYS_28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: day_limit = DAYS_30;
         default:                                    day_limit = DAYS_31;
      endcase
   end

   assign year_ok  = (q_data.year <= limits.current_year) && (q_data.year >= limits.min_year);
   assign month_ok = (q_data.month >= 7'd1) && (q_data.month <= MONTH_MAX) &&
                     !((q_data.year == limits.current_year) &&
                       (q_data.month > MONTH_W'(limits.current_month)));
   assign date_ok_in = q_data.format_ok && year_ok && month_ok &&
                       (q_data.day >= 7'd1) && (q_data.day <= day_limit);

   // Take a word whenever the output register is free or being drained
   assign pop = q_not_empty && (!valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         fmt_ff     <= q_data.format_ok;
         date_ok_ff <= date_ok_in;
         year_ff    <= q_data.year;
         month_ff   <= q_data.month;
         day_ff     <= q_data.day;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.format_ok  = fmt_ff;
   assign rsp.date_valid = date_ok_ff;
   assign rsp.year_out   = year_ff;
   assign rsp.month_out  = month_ff;
   assign rsp.day_out    = day_ff;

   a_valid_needs_form: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && date_ok_ff) |-> fmt_ff)
      else $error("date valid without good form");

   a_bad_form_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !fmt_ff) |-> (year_ff == '0 && month_ff == '0 && day_ff == '0))
      else $error("fields not cleared on bad form");

   a_load_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("response not loaded after pop");

endmodule

[rtl/date_string_validator_unit.sv]
// Top level of the date string validator: register port, parser, queue and checker.
// Depends on dsv_pkg, the channel interfaces, dsv_front, dsv_queue and dsv_back.
//
// The block takes one character per cycle on the request channel and checks the text
// against YYYY-M(M)-D(D); on the character flagged last it returns one response with the
// form verdict, the parsed year, month and day (zero on a bad form) and the calendar
// verdict against the programmed limits (min_year, current_year, current_month). The
// parser accepts a character every cycle while its two-entry result queue has room; the
// final character's word is pushed into the queue and then into the response register
// once that is free; a full queue under response back-pressure stalls the request side.
// Registers are written through the csr channel, which is always ready; indexes past
// min_year are ignored. Write the registers only while no string is in flight.
module date_string_validator_unit (
   input  logic       clock,
   input  logic       reset,
   dsv_req_if.sink    req_chan,
   dsv_rsp_if.source  rsp_chan,
   dsv_csr_if.sink    csr_chan
);
   import dsv_pkg::*;

   limits_type limits_ff;
   parsed_type push_data;
   parsed_type pop_data;
   logic       push;
   logic       pop;
   logic       q_full;
   logic       q_not_empty;

   // Register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.current_year  <= CURRENT_YEAR_RESET;
         limits_ff.current_month <= CURRENT_MONTH_RESET;
         limits_ff.min_year      <= MIN_YEAR_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_index_type'(csr_chan.reg_index))
            CSR_CURRENT_YEAR:  limits_ff.current_year  <= YEAR_W'(csr_chan.wr_data);
            CSR_CURRENT_MONTH: limits_ff.current_month <= csr_chan.wr_data[CMON_W-1:0];
            CSR_MIN_YEAR:      limits_ff.min_year      <= YEAR_W'(csr_chan.wr_data);
            default: ;
         endcase
      end
   end

   dsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   dsv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .pop_data  (pop_data)
   );

   dsv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (pop_data),
      .pop         (pop),
      .limits      (limits_ff),
      .rsp         (rsp_chan)
   );

endmodule
